>>> hdl/cag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cag_pkg
// Shared constants, types and functions of the cyclic automaton generation
// block: grid limits, widths, register indexes and the predator rule.
// ----------------------------------------------------------------------------
package cag_pkg;

	localparam int MAX_COLS   = 128;
	localparam int MAX_ROWS   = 128;
	localparam int LINE_DEPTH = MAX_COLS + 2;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);
	localparam int MAX_SIDE   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int POS_W      = $clog2(MAX_SIDE + 3);

	localparam int COLOR_W    = 2;
	localparam int LINE_W     = 2 * COLOR_W;
	localparam int IDX_W      = 7;
	localparam int REG_W      = 8;
	localparam int THR_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int NCOUNT_W   = 4;

	typedef logic [COLOR_W-1:0] color_t;

	localparam color_t COLOR_NONE  = 2'd0;
	localparam color_t COLOR_ONE   = 2'd1;
	localparam color_t COLOR_TWO   = 2'd2;
	localparam color_t COLOR_THREE = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLS  = 2'd0,
		REG_GRID_ROWS  = 2'd1,
		REG_THRESHOLD  = 2'd2
	} reg_index_t;

	// Position of the request just accepted, as seen by the datapath.
	typedef struct packed {
		logic              live;
		logic              produce;
		logic [ADDR_W-1:0] addr;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic              last;
	} pos_t;

	function automatic color_t predator_of(input color_t c);
		color_t p;
		case (c)
			COLOR_ONE: p = COLOR_THREE;
			COLOR_TWO: p = COLOR_ONE;
			default:   p = COLOR_TWO;
		endcase
		return p;
	endfunction

	// Zero acts as one, values beyond the grid limit act as the limit.
	function automatic logic [POS_W-1:0] clamp_size(input logic [REG_W-1:0] v,
			input int limit);
		logic [POS_W-1:0] r;
		if (v == '0)
			r = POS_W'(1);
		else if (int'(v) > limit)
			r = POS_W'(limit);
		else
			r = POS_W'(v);
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/cag_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cag_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// The read data holds while no read is issued.
// ----------------------------------------------------------------------------
module cag_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 130
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hdl/cag_position.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cag_position
// Padded row and column counters. Decodes the position of each accepted
// request, whether it lies inside the frame and whether it yields a result.
// ----------------------------------------------------------------------------
module cag_position (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         accept,
	input  wire                         frame_start,
	input  wire  [cag_pkg::POS_W-1:0]   cols,
	input  wire  [cag_pkg::POS_W-1:0]   rows,
	output cag_pkg::pos_t               pos
);

	localparam int PW = cag_pkg::POS_W;

	logic [PW-1:0] col_q, row_q;
	logic [PW-1:0] c0, r0, c1, r1, cn;
	logic [PW-1:0] cols_end, rows_end;

	always_comb begin
		cols_end = cols + PW'(2);
		rows_end = rows + PW'(2);
		c0 = frame_start ? '0 : col_q;
		r0 = frame_start ? '0 : row_q;
		// A row that is already complete under the current width wraps first.
		if (c0 >= cols_end) begin
			c1 = '0;
			r1 = r0 + PW'(1);
		end else begin
			c1 = c0;
			r1 = r0;
		end
		cn = c1 + PW'(1);
		pos.live    = r1 < rows_end;
		pos.produce = pos.live && (r1 >= PW'(2)) && (c1 >= PW'(2)) && (c1 < cols_end);
		pos.addr    = cag_pkg::ADDR_W'(c1);
		pos.row     = cag_pkg::IDX_W'(r1 - PW'(2));
		pos.col     = cag_pkg::IDX_W'(c1 - PW'(2));
		pos.last    = (r1 == rows + PW'(1)) && (c1 == cols + PW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!pos.live) begin
				col_q <= c1;
				row_q <= r1;
			end else if (cn >= cols_end) begin
				col_q <= '0;
				row_q <= r1 + PW'(1);
			end else begin
				col_q <= cn;
				row_q <= r1;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/cag_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cag_window
// 3x3 neighborhood window, the cyclic conversion rule and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module cag_window (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           step,
	input  wire  [cag_pkg::COLOR_W-1:0]   up,
	input  wire  [cag_pkg::COLOR_W-1:0]   mid,
	input  wire  [cag_pkg::COLOR_W-1:0]   color,
	input  wire                           produce,
	input  wire  [cag_pkg::IDX_W-1:0]     row,
	input  wire  [cag_pkg::IDX_W-1:0]     col,
	input  wire                           last,
	input  wire  [cag_pkg::THR_W-1:0]     threshold,
	input  wire                           out_stall,
	output logic                          out_valid,
	output logic [cag_pkg::COLOR_W-1:0]   next_color,
	output logic [cag_pkg::IDX_W-1:0]     cell_row,
	output logic [cag_pkg::IDX_W-1:0]     cell_col,
	output logic                          frame_last
);

	// Window rows are top, middle, bottom; columns are left, center, right.
	cag_pkg::color_t win_q [3][3];
	cag_pkg::color_t nb [8];
	cag_pkg::color_t centre, pred, result;
	logic [cag_pkg::NCOUNT_W-1:0] hits;

	always_comb begin
		// Neighbors of the window as it stands after this shift.
		nb[0] = win_q[0][1];
		nb[1] = win_q[0][2];
		nb[2] = up;
		nb[3] = win_q[1][1];
		nb[4] = mid;
		nb[5] = win_q[2][1];
		nb[6] = win_q[2][2];
		nb[7] = color;
		centre = win_q[1][2];
		pred   = cag_pkg::predator_of(centre);
		hits   = '0;
		for (int i = 0; i < 8; i++)
			hits = hits + cag_pkg::NCOUNT_W'(nb[i] == pred);
		if (centre == cag_pkg::COLOR_NONE)
			result = cag_pkg::COLOR_NONE;
		else if (hits >= threshold)
			result = pred;
		else
			result = centre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= cag_pkg::COLOR_NONE;
		end else if (step) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up;
			win_q[1][2] <= mid;
			win_q[2][2] <= color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (step)
			out_valid <= produce;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			next_color <= result;
			cell_row   <= row;
			cell_col   <= col;
			frame_last <= last;
		end
	end

endmodule
`default_nettype wire

>>> hdl/cyclic_automaton_generation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_automaton_generation
// One generation of a three-color cyclic automaton with a Moore
// neighborhood over a zero-bordered grid streamed in raster order.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid, in_stall   cell_color, frame_start
//  out      out_valid, out_stall next_color, cell_row, cell_col, frame_last
//  config   cfg_we               cfg_index, cfg_data
//
// One request is accepted per cycle unless in_stall is high; the result of
// the request that completes its window passes the registered line buffer
// read and the output register. The line buffer RAM is read at accept and
// written back at step, with forwarding for back-to-back hits on the same
// column. in_stall rises only while a result is held by out_stall.
// Reset clears counters, window and valids; no clearing pass is needed.
// ----------------------------------------------------------------------------
module cyclic_automaton_generation (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire  [cag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [cag_pkg::REG_W-1:0]        cfg_data,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [cag_pkg::COLOR_W-1:0]      cell_color,
	input  wire                              frame_start,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [cag_pkg::COLOR_W-1:0]      next_color,
	output logic [cag_pkg::IDX_W-1:0]        cell_row,
	output logic [cag_pkg::IDX_W-1:0]        cell_col,
	output logic                             frame_last
);

	localparam int CW = cag_pkg::COLOR_W;

	logic [cag_pkg::REG_W-1:0] grid_cols_q, grid_rows_q;
	logic [cag_pkg::THR_W-1:0] threshold_q;
	logic [cag_pkg::POS_W-1:0] cols, rows;

	cag_pkg::pos_t pos;
	logic accept, advance, step;

	logic                       valid_s1, produce_s1, last_s1, fwd_s1;
	cag_pkg::color_t            color_s1;
	logic [cag_pkg::ADDR_W-1:0] addr_s1;
	logic [cag_pkg::IDX_W-1:0]  row_s1, col_s1;
	logic [cag_pkg::LINE_W-1:0] fwd_data_s1, rd_data, line_data, wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= cag_pkg::REG_W'(120);
			grid_rows_q <= cag_pkg::REG_W'(80);
			threshold_q <= cag_pkg::THR_W'(3);
		end else if (cfg_we) begin
			case (cfg_index)
				cag_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data;
				cag_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data;
				cag_pkg::REG_THRESHOLD: threshold_q <= cfg_data[cag_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign cols = cag_pkg::clamp_size(grid_cols_q, cag_pkg::MAX_COLS);
	assign rows = cag_pkg::clamp_size(grid_rows_q, cag_pkg::MAX_ROWS);

	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign step     = valid_s1 && advance;

	cag_position u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.frame_start (frame_start),
		.cols        (cols),
		.rows        (rows),
		.pos         (pos)
	);

	// Line buffer entry: upper half holds the row above, lower half the middle row.
	assign line_data = fwd_s1 ? fwd_data_s1 : rd_data;
	assign wr_data   = {line_data[CW-1:0], color_s1};

	cag_ram #(
		.WIDTH (cag_pkg::LINE_W),
		.DEPTH (cag_pkg::LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (step),
		.waddr (addr_s1),
		.wdata (wr_data),
		.re    (accept),
		.raddr (pos.addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= pos.live;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			color_s1    <= cell_color;
			addr_s1     <= pos.addr;
			produce_s1  <= pos.produce;
			row_s1      <= pos.row;
			col_s1      <= pos.col;
			last_s1     <= pos.last;
			// The RAM returns stale data when the entry is written this cycle.
			fwd_s1      <= step && (addr_s1 == pos.addr);
			fwd_data_s1 <= wr_data;
		end
	end

	cag_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.up         (line_data[2*CW-1:CW]),
		.mid        (line_data[CW-1:0]),
		.color      (color_s1),
		.produce    (produce_s1),
		.row        (row_s1),
		.col        (col_s1),
		.last       (last_s1),
		.threshold  (threshold_q),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.next_color (next_color),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.frame_last (frame_last)
	);

endmodule
`default_nettype wire

>>> hdl/cag_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cag_checker
// Port-level checks of the cyclic automaton generation block, bound to the
// top level.
// ----------------------------------------------------------------------------
module cag_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_stall,
	input wire                              out_valid,
	input wire                              out_stall,
	input wire [cag_pkg::COLOR_W-1:0]       next_color,
	input wire [cag_pkg::IDX_W-1:0]         cell_row,
	input wire [cag_pkg::IDX_W-1:0]         cell_col,
	input wire                              frame_last
);

	// A held result keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_color) &&
			$stable(cell_row) && $stable(cell_col) && $stable(frame_last))
		else $error("result changed while stalled");

	// Input backpressure only comes from a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A fresh result follows an accepted request through the s1 stage and the output register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching request");

endmodule

bind cyclic_automaton_generation cag_checker u_cag_checker (.*);
`default_nettype wire

>>> bench/generation_checker.sv
// ----------------------------------------------------------------------------
// generation_checker
// Watches the configuration port and both channels of the cyclic
// automaton block. It keeps its own line buffers, window and position counters
// and predicts the next color of every interior cell. Each result that leaves
// the block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module generation_checker
	import cag_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  color_t               cell_color,
	input  logic                 frame_start,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  color_t               next_color,
	input  logic [IDX_W-1:0]     cell_row,
	input  logic [IDX_W-1:0]     cell_col,
	input  logic                 frame_last,
	output int                   fail_count,
	output int                   pending,
	output int                   results_checked
);

	typedef struct packed {
		color_t           next_color;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
	} cell_result_t;

	logic [REG_W-1:0] cols_reg;
	logic [REG_W-1:0] rows_reg;
	logic [THR_W-1:0] threshold_reg;

	color_t upper_line [0:LINE_DEPTH-1];
	color_t middle_line [0:LINE_DEPTH-1];
	color_t win [0:2][0:2];
	int row_pos;
	int col_pos;

	cell_result_t expected_cells [$];
	int mismatches;
	int compared;

	function automatic int grid_extent(input logic [REG_W-1:0] v, input int limit);
		if (v == '0)
			return 1;
		if (int'(v) > limit)
			return limit;
		return int'(v);
	endfunction

	// The color that takes over a cell of the given color.
	function automatic color_t taker_of(input color_t c);
		case (c)
			COLOR_ONE: return COLOR_THREE;
			COLOR_TWO: return COLOR_ONE;
			default:   return COLOR_TWO;
		endcase
	endfunction

	task automatic clear_state();
		int i;
		cols_reg = 8'd120;
		rows_reg = 8'd80;
		threshold_reg = 4'd3;
		for (i = 0; i < LINE_DEPTH; i++) begin
			upper_line[i] = COLOR_NONE;
			middle_line[i] = COLOR_NONE;
		end
		for (i = 0; i < 9; i++)
			win[i / 3][i % 3] = COLOR_NONE;
		row_pos = 0;
		col_pos = 0;
		expected_cells.delete();
		mismatches = 0;
		compared = 0;
	endtask

	// Advances the window by one padded cell and queues the next color of the
	// interior cell whose neighborhood has just become complete.
	task automatic step_generation(input color_t color, input logic start);
		int cols;
		int rows;
		int r;
		int c;
		int i;
		int j;
		int hits;
		color_t above;
		color_t middle;
		color_t centre;
		color_t taker;
		cell_result_t res;
		cols = grid_extent(cols_reg, MAX_COLS);
		rows = grid_extent(rows_reg, MAX_ROWS);
		if (start) begin
			row_pos = 0;
			col_pos = 0;
		end
		if (col_pos >= cols + 2) begin
			col_pos = 0;
			row_pos++;
		end
		r = row_pos;
		c = col_pos;
		// Once the padded frame is complete, cells are dropped until the next start.
		if (r < rows + 2) begin
			above = upper_line[c];
			middle = middle_line[c];
			upper_line[c] = middle;
			middle_line[c] = color;
			for (i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = above;
			win[1][2] = middle;
			win[2][2] = color;
			if (r >= 2 && c >= 2 && c <= cols + 1) begin
				centre = win[1][1];
				taker = taker_of(centre);
				hits = 0;
				for (i = 0; i < 3; i++)
					for (j = 0; j < 3; j++)
						if (!(i == 1 && j == 1) && win[i][j] == taker)
							hits++;
				if (centre == COLOR_NONE)
					res.next_color = COLOR_NONE;
				else if (hits >= int'(threshold_reg))
					res.next_color = taker;
				else
					res.next_color = centre;
				res.row = IDX_W'(r - 2);
				res.col = IDX_W'(c - 2);
				res.last = (r - 2 == rows - 1) && (c - 2 == cols - 1);
				expected_cells.push_back(res);
			end
			col_pos = c + 1;
			if (col_pos >= cols + 2) begin
				col_pos = 0;
				row_pos = r + 1;
			end
		end
	endtask

	task automatic check_result();
		cell_result_t want;
		if (expected_cells.size() == 0) begin
			$error("unexpected result at row %0d col %0d: no request waiting", cell_row,
				cell_col);
			mismatches++;
		end else begin
			want = expected_cells.pop_front();
			compared++;
			if (next_color !== want.next_color) begin
				$error("next_color at row %0d col %0d: expected %0d, actual %0d", want.row,
					want.col, want.next_color, next_color);
				mismatches++;
			end
			if (cell_row !== want.row) begin
				$error("cell_row: expected %0d, actual %0d", want.row, cell_row);
				mismatches++;
			end
			if (cell_col !== want.col) begin
				$error("cell_col: expected %0d, actual %0d", want.col, cell_col);
				mismatches++;
			end
			if (frame_last !== want.last) begin
				$error("frame_last at row %0d col %0d: expected %0d, actual %0d", want.row,
					want.col, want.last, frame_last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			fail_count <= 0;
			pending <= 0;
			results_checked <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (cfg_we) begin
				case (cfg_index)
					REG_GRID_COLS: cols_reg = cfg_data;
					REG_GRID_ROWS: rows_reg = cfg_data;
					REG_THRESHOLD: threshold_reg = cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				step_generation(cell_color, frame_start);
			fail_count <= mismatches;
			pending <= expected_cells.size();
			results_checked <= compared;
		end
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams padded grids through the cyclic automaton block under a
// range of grid sizes and thresholds, with bursty requests and a stalling
// receiver. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	import cag_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 7;
	localparam int ITEM_TARGET  = 1950;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 400000;

	// Index with no register behind it; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HALF,
		STALL_HEAVY
	} stall_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	color_t               cell_color;
	logic                 frame_start;
	logic                 out_valid;
	logic                 out_stall;
	color_t               next_color;
	logic [IDX_W-1:0]     cell_row;
	logic [IDX_W-1:0]     cell_col;
	logic                 frame_last;

	int fail_count;
	int pending;
	int results_checked;

	int cycles;
	int burst_left;
	int stall_run;
	stall_mode_t stall_mode;
	int cells_sent;
	int frames_sent;
	int settings_used;
	int pad_cols;
	int pad_rows;

	cyclic_automaton_generation u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cell_color  (cell_color),
		.frame_start (frame_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.next_color  (next_color),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.frame_last  (frame_last)
	);

	generation_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cell_color      (cell_color),
		.frame_start     (frame_start),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.next_color      (next_color),
		.cell_row        (cell_row),
		.cell_col        (cell_col),
		.frame_last      (frame_last),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: timed out after %0d cycles, %0d results outstanding", cycles,
				pending);
			$display("tb: failure");
			$finish;
		end
	end

	// The receiver switches between stall patterns after runs of random length.
	always @(posedge clk) begin
		if (stall_run == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_run = $urandom_range(16, 160);
		end
		stall_run--;
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
			default:     out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	function automatic int padded_extent(input logic [REG_W-1:0] v, input int limit);
		if (v == '0)
			return 3;
		if (int'(v) > limit)
			return limit + 2;
		return int'(v) + 2;
	endfunction

	// Presents one request and returns at the edge that accepts it.
	task automatic push_cell(input color_t color, input logic start);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cell_color <= color;
		frame_start <= start;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Border cells carry no result, so the block may still be busy after the
	// last expected result; a short pause covers its latency.
	task automatic settle();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_grid(input logic [REG_W-1:0] cols_v, input logic [REG_W-1:0] rows_v,
			input logic [THR_W-1:0] thr_v, input bit poke_unused);
		logic [REG_W-1:0] thr_word;
		thr_word = REG_W'($urandom);
		thr_word[THR_W-1:0] = thr_v;
		cfg_we <= 1'b1;
		cfg_index <= REG_GRID_COLS;
		cfg_data <= cols_v;
		@(posedge clk);
		cfg_index <= REG_GRID_ROWS;
		cfg_data <= rows_v;
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_data <= thr_word;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= REG_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		pad_cols = padded_extent(cols_v, MAX_COLS);
		pad_rows = padded_extent(rows_v, MAX_ROWS);
		settings_used++;
	endtask

	// Sends a padded frame, or only its first cut_at cells when cut_at is positive.
	task automatic send_frame(input int cut_at, input int pause_at);
		int total;
		int idx;
		int r;
		int c;
		color_t bias;
		color_t pick;
		total = (cut_at > 0) ? cut_at : pad_rows * pad_cols;
		bias = color_t'($urandom_range(1, 3));
		for (idx = 0; idx < total; idx++) begin
			r = idx / pad_cols;
			c = idx % pad_cols;
			if (r == 0 || r == pad_rows - 1 || c == 0 || c == pad_cols - 1)
				pick = ($urandom_range(0, 15) == 0) ? color_t'($urandom) : COLOR_NONE;
			else if ($urandom_range(0, 11) == 0)
				pick = COLOR_NONE;
			else if ($urandom_range(0, 1) == 0)
				pick = bias;
			else
				pick = color_t'($urandom_range(1, 3));
			if (idx == pause_at)
				hold_until_drained();
			push_cell(pick, idx == 0);
			cells_sent++;
		end
		if (cut_at <= 0)
			frames_sent++;
	endtask

	// Cells past the end of a finished frame; the block must drop them.
	task automatic send_stray(input int n);
		int i;
		for (i = 0; i < n; i++)
			push_cell(color_t'($urandom), 1'b0);
	endtask

	task automatic run_setting(input logic [REG_W-1:0] cols_v, input logic [REG_W-1:0] rows_v,
			input logic [THR_W-1:0] thr_v, input bit poke_unused);
		int total;
		int frames;
		int k;
		int kind;
		program_grid(cols_v, rows_v, thr_v, poke_unused);
		total = pad_rows * pad_cols;
		frames = (total > 200) ? 1 : $urandom_range(1, 4);
		for (k = 0; k < frames; k++) begin
			kind = $urandom_range(0, 9);
			// The last frame of a setting always completes so the grid can change safely.
			if (kind == 0 && k != frames - 1) begin
				send_frame($urandom_range(1, total - 1), -1);
			end else begin
				send_frame(-1, ($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : -1);
				if (kind == 1)
					send_stray($urandom_range(1, 5));
			end
		end
		settle();
	endtask

	initial begin
		color_t demo [0:17];
		int i;
		logic [REG_W-1:0] cols_v;
		logic [REG_W-1:0] rows_v;
		logic [THR_W-1:0] thr_v;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRID_COLS;
		cfg_data = '0;
		in_valid = 1'b0;
		cell_color = COLOR_NONE;
		frame_start = 1'b0;
		out_stall = 1'b0;
		stall_run = 0;
		cycles = 0;
		burst_left = 0;
		cells_sent = 0;
		frames_sent = 0;
		settings_used = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One row of four: each color next to its taker, and a cell with no color.
		demo = '{COLOR_NONE, COLOR_THREE, COLOR_ONE, COLOR_TWO, COLOR_THREE, COLOR_NONE,
			COLOR_NONE, COLOR_ONE, COLOR_TWO, COLOR_THREE, COLOR_NONE, COLOR_NONE,
			COLOR_NONE, COLOR_NONE, COLOR_NONE, COLOR_NONE, COLOR_TWO, COLOR_NONE};
		program_grid(8'd4, 8'd1, 4'd1, 1'b0);
		for (i = 0; i < 18; i++) begin
			push_cell(demo[i], i == 0);
			cells_sent++;
		end
		frames_sent++;
		send_stray(3);
		settle();

		// Widest and tallest grids, out-of-range sizes and thresholds.
		run_setting(8'd128, 8'd1, 4'd8, 1'b0);
		run_setting(8'd0, 8'd255, 4'd0, 1'b1);
		run_setting(8'd255, 8'd1, 4'd9, 1'b0);
		run_setting(8'd0, 8'd0, 4'd15, 1'b0);

		while (cells_sent < ITEM_TARGET) begin
			cols_v = ($urandom_range(0, 7) == 0) ? REG_W'($urandom_range(13, 40)) :
				REG_W'($urandom_range(1, 12));
			rows_v = REG_W'($urandom_range(1, 8));
			thr_v = ($urandom_range(0, 3) == 0) ? THR_W'($urandom_range(0, 15)) :
				THR_W'($urandom_range(1, 8));
			run_setting(cols_v, rows_v, thr_v, $urandom_range(0, 9) == 0);
		end

		$display("tb: %0d cells streamed, %0d complete frames, %0d grid settings", cells_sent,
			frames_sent, settings_used);
		$display("tb: %0d results compared, %0d mismatches", results_checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
